### src/pvs_pkg.sv
package pvs_pkg;

    localparam int LINE_W  = 9;
    localparam int SLICE_W = 5;
    localparam int ROW_W   = 8;
    localparam int COLOR_W = 4;

    localparam logic [LINE_W-1:0]  LINES_PER_FRAME = 9'd312;
    localparam logic [SLICE_W-1:0] LAST_SLICE      = 5'd31;

    // line map boundaries
    localparam logic [LINE_W-1:0] LINE_LONG_LAST   = 9'd2;
    localparam logic [LINE_W-1:0] LINE_LONG_SHORT  = 9'd3;
    localparam logic [LINE_W-1:0] LINE_SHORT_LAST  = 9'd5;
    localparam logic [LINE_W-1:0] LINE_TOP_BORDER  = 9'd36;
    localparam logic [LINE_W-1:0] LINE_BOT_BORDER  = 9'd293;
    localparam logic [LINE_W-1:0] LINE_SHORT_FIRST = 9'd310;

    // slice positions within a line
    localparam logic [SLICE_W-1:0] SLICE_HALF     = 5'd16;
    localparam logic [SLICE_W-1:0] SLICE_HS_HI    = 5'd2;
    localparam logic [SLICE_W-1:0] SLICE_BORDER   = 5'd6;
    localparam logic [SLICE_W-1:0] SLICE_GAP_FST  = 5'd8;
    localparam logic [SLICE_W-1:0] SLICE_GAP_LST  = 5'd28;

    typedef enum logic [2:0] {
        KIND_HS_LO  = 3'd0,
        KIND_HS_HI  = 3'd1,
        KIND_BORDER = 3'd2,
        KIND_GAP    = 3'd3,
        KIND_VS_LO  = 3'd4,
        KIND_VS_HI  = 3'd5
    } kind_t;

    // packed from the lowest bit up: slice_kind, colour, line_number,
    // slice_index, pixel_row
    typedef struct packed {
        logic [ROW_W-1:0]   pixel_row;
        logic [SLICE_W-1:0] slice_index;
        logic [LINE_W-1:0]  line_number;
        logic [COLOR_W-1:0] colour;
        kind_t              slice_kind;
    } slice_word_t;

    localparam int WORD_W  = $bits(slice_word_t);
    localparam int TDATA_W = ((WORD_W + 7) / 8) * 8;

endpackage

### src/pvs_slice_decode.sv
module pvs_slice_decode (
    input  logic [pvs_pkg::LINE_W-1:0]  line_number,
    input  logic [pvs_pkg::SLICE_W-1:0] slice_index,
    input  logic [pvs_pkg::ROW_W-1:0]   row,
    input  logic [pvs_pkg::COLOR_W-1:0] border_colour,
    output pvs_pkg::slice_word_t        word,
    output logic                        frame_end,
    output logic                        active
);
    import pvs_pkg::*;

    kind_t kind;
    kind_t long_kind;
    kind_t short_kind;

    // only the position within each half line matters for vsync
    assign long_kind  = (slice_index[3:0] == 4'hf) ? KIND_VS_HI : KIND_VS_LO;
    assign short_kind = (slice_index[3:0] == 4'h0) ? KIND_VS_LO : KIND_VS_HI;

    assign active = (line_number > LINE_TOP_BORDER) && (line_number < LINE_BOT_BORDER);

    always_comb
    begin
        if (line_number <= LINE_LONG_LAST) begin
            kind = long_kind;
        end else if (line_number == LINE_LONG_SHORT) begin
            kind = (slice_index < SLICE_HALF) ? long_kind : short_kind;
        end else if ((line_number <= LINE_SHORT_LAST) ||
                     (line_number >= LINE_SHORT_FIRST)) begin
            kind = short_kind;
        end else if (slice_index < SLICE_HS_HI) begin
            kind = KIND_HS_LO;
        end else if (slice_index < SLICE_BORDER) begin
            kind = KIND_HS_HI;
        end else if (!active) begin
            kind = KIND_BORDER;
        end else if ((slice_index >= SLICE_GAP_FST) && (slice_index <= SLICE_GAP_LST)) begin
            kind = KIND_GAP;
        end else begin
            kind = KIND_BORDER;
        end
    end

    assign word.slice_kind  = kind;
    assign word.colour      = (kind == KIND_BORDER) ? border_colour : '0;
    assign word.line_number = line_number;
    assign word.slice_index = slice_index;
    assign word.pixel_row   = active ? row : '0;

    assign frame_end = (slice_index == LAST_SLICE) && (line_number >= LINES_PER_FRAME);

endmodule

### src/pal_video_sync_sequencer.sv
// pal video slice sequencer, progressive, 312 lines of 32 slices
//
// s_* channel: one word per 2 us slice time, s_tdata[0] is the tick flag.
//   a word with tick low is taken and dropped without changing any counter.
// m_* channel: one word per tick, carrying the slice code for the current
//   line and slice position; m_tlast marks slice 31 of line 312.
// cfg_* channel: 4-bit border colour, always ready, write it while idle.
//
// path: a tick word goes into the input register and, once the output
//   register is free, is decoded into it and shows on m_*.
// throughput: one word per cycle while m_tready holds high; the slice, line and
//   row counters advance in the same cycle that a tick leaves the input register.
// stall: when m_tready is low the output word holds, the input register
//   fills behind it and s_tready drops; nothing is lost or repeated.
// reset: line 1, slice 0, row 0, border colour 0, both registers empty.
module pal_video_sync_sequencer #(
    parameter int BITMAP_ROWS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,    // tick
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pvs_pkg::TDATA_W-1:0]   m_tdata,    // slice_kind, colour, line_number,
                                                      // slice_index, pixel_row
    output logic                          m_tlast,    // frame_end
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pvs_pkg::COLOR_W-1:0]   cfg_data
);
    import pvs_pkg::*;

    localparam logic [ROW_W:0] ROWS = (ROW_W+1)'(BITMAP_ROWS);

    // input register
    logic in_valid_reg, in_valid_next;
    logic in_tick_reg;

    // output register
    logic        out_valid_reg, out_valid_next;
    slice_word_t out_word_reg;
    logic        out_last_reg;

    // timing counters
    logic [LINE_W-1:0]  line_reg, line_next;
    logic [SLICE_W-1:0] slice_reg, slice_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COLOR_W-1:0] colour_reg;

    slice_word_t dec_word;
    logic        dec_frame_end;
    logic        dec_active;
    logic        out_free;
    logic        in_move;
    logic        step;
    logic [ROW_W:0] row_inc;

    pvs_slice_decode u_decode (
        .line_number   (line_reg),
        .slice_index   (slice_reg),
        .row           (row_reg),
        .border_colour (colour_reg),
        .word          (dec_word),
        .frame_end     (dec_frame_end),
        .active        (dec_active)
    );

    // a tick-low word needs no output slot, so it always moves on
    assign out_free = !out_valid_reg || m_tready;
    assign in_move  = in_valid_reg && (out_free || !in_tick_reg);
    assign step     = in_move && in_tick_reg;
    assign s_tready = !in_valid_reg || in_move;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = (s_tvalid && s_tready) ? 1'b1 : (in_move ? 1'b0 : in_valid_reg);
    assign out_valid_next = step ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    assign row_inc = {1'b0, row_reg} + 1'b1;

    always_comb
    begin
        slice_next = slice_reg;
        line_next  = line_reg;
        row_next   = row_reg;
        if (step) begin
            if (slice_reg != LAST_SLICE) begin
                slice_next = slice_reg + 1'b1;
            end else begin
                slice_next = '0;
                if (dec_active) begin
                    row_next = (row_inc >= ROWS) ? '0 : row_inc[ROW_W-1:0];
                end
                if (line_reg >= LINES_PER_FRAME) begin
                    line_next = LINE_W'(1);
                end else begin
                    line_next = line_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            line_reg      <= LINE_W'(1);
            slice_reg     <= '0;
            row_reg       <= '0;
            colour_reg    <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            line_reg      <= line_next;
            slice_reg     <= slice_next;
            row_reg       <= row_next;
            if (cfg_valid && cfg_ready) begin
                colour_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            in_tick_reg <= s_tdata[0];
        end
        if (step) begin
            out_word_reg <= dec_word;
            out_last_reg <= dec_frame_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W-WORD_W){1'b0}}, out_word_reg};
    assign m_tlast  = out_last_reg;

    // line counter stays within the frame
    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        (line_reg >= LINE_W'(1)) && (line_reg <= LINES_PER_FRAME))
        else $error("line counter out of range");

    // end of a line returns the slice counter to zero
    a_slice_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (slice_reg == LAST_SLICE)) |=> (slice_reg == '0))
        else $error("slice counter did not wrap");

    // frame end flag only on the last slice of the last line
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |->
        ((out_word_reg.line_number == LINES_PER_FRAME) &&
         (out_word_reg.slice_index == LAST_SLICE)))
        else $error("frame end flag on wrong slice");

    // an output word only comes from a tick word in the input register
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_tick_reg))
        else $error("output word without a tick");

endmodule

### tb/pvs_slice_checker.sv
`timescale 1ns / 100ps

// watches the tick, slice and colour channels, predicts each slice word and
// compares it with what the sequencer puts out
module pvs_slice_checker #(
    parameter int BITMAP_ROWS = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,     // tick
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [pvs_pkg::TDATA_W-1:0] m_tdata,     // slice_kind, colour, line_number,
                                                     // slice_index, pixel_row
    input  logic                        m_tlast,     // frame_end
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [pvs_pkg::COLOR_W-1:0] cfg_data,
    output int                          fail_count,
    output int                          outstanding
);
    import pvs_pkg::*;

    typedef struct packed {
        slice_word_t word;
        logic        frame_end;
    } slice_expect_t;

    slice_expect_t      slice_words_due[$];
    logic [COLOR_W-1:0] border_colour;
    logic [LINE_W-1:0]  line_no;
    logic [SLICE_W-1:0] slice_no;
    logic [ROW_W-1:0]   row_no;

    // lines 37..292 show the bitmap
    function automatic logic in_picture(input logic [LINE_W-1:0] ln);
        return (ln > 9'd36) && (ln < 9'd293);
    endfunction

    // half line of broad vsync: low except the last slice of the half
    function automatic kind_t broad_pulse(input logic [SLICE_W-1:0] sl);
        return (sl[3:0] == 4'd15) ? KIND_VS_HI : KIND_VS_LO;
    endfunction

    // half line of equalizing pulse: low only on the first slice of the half
    function automatic kind_t narrow_pulse(input logic [SLICE_W-1:0] sl);
        return (sl[3:0] == 4'd0) ? KIND_VS_LO : KIND_VS_HI;
    endfunction

    function automatic kind_t slice_code(input logic [LINE_W-1:0] ln,
                                         input logic [SLICE_W-1:0] sl);
        if (ln <= 9'd2)
            return broad_pulse(sl);
        if (ln == 9'd3)
            return (sl < 5'd16) ? broad_pulse(sl) : narrow_pulse(sl);
        if (ln <= 9'd5 || ln >= 9'd310)
            return narrow_pulse(sl);
        if (sl < 5'd2)
            return KIND_HS_LO;
        if (sl < 5'd6)
            return KIND_HS_HI;
        if (!in_picture(ln))
            return KIND_BORDER;
        if (sl >= 5'd8 && sl <= 5'd28)
            return KIND_GAP;
        return KIND_BORDER;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen)
        begin
            fail_count++;
            $error("%s mismatch: expected %0d, got %0d", name, want, seen);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        slice_expect_t  due;
        slice_word_t    got;
        logic [ROW_W:0] next_row;
        if (!rst_n)
        begin
            border_colour = '0;
            line_no       = 9'd1;
            slice_no      = '0;
            row_no        = '0;
            slice_words_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                border_colour = cfg_data;

            // a word with the tick low is dropped
            if (s_tvalid && s_tready && s_tdata[0])
            begin
                due.word.slice_kind  = slice_code(line_no, slice_no);
                due.word.colour      = (due.word.slice_kind == KIND_BORDER) ?
                                       border_colour : '0;
                due.word.line_number = line_no;
                due.word.slice_index = slice_no;
                due.word.pixel_row   = in_picture(line_no) ? row_no : '0;
                due.frame_end        = (slice_no == 5'd31) && (line_no == 9'd312);
                slice_words_due.push_back(due);

                if (slice_no != 5'd31)
                    slice_no++;
                else
                begin
                    slice_no = '0;
                    if (in_picture(line_no))
                    begin
                        next_row = {1'b0, row_no} + 9'd1;
                        row_no = (next_row >= BITMAP_ROWS) ? '0 : next_row[ROW_W-1:0];
                    end
                    if (line_no >= 9'd312)
                        line_no = 9'd1;
                    else
                        line_no++;
                end
            end

            if (m_tvalid && m_tready)
            begin
                got = m_tdata[WORD_W-1:0];
                if (slice_words_due.size() == 0)
                begin
                    fail_count++;
                    $error("slice word with none expected: tdata %h", m_tdata);
                end
                else
                begin
                    due = slice_words_due.pop_front();
                    check_field("slice_kind", due.word.slice_kind, got.slice_kind);
                    check_field("colour", due.word.colour, got.colour);
                    check_field("line_number", due.word.line_number, got.line_number);
                    check_field("slice_index", due.word.slice_index, got.slice_index);
                    check_field("pixel_row", due.word.pixel_row, got.pixel_row);
                    check_field("frame_end", due.frame_end, m_tlast);
                end
            end
        end
        outstanding = slice_words_due.size();
    end

endmodule

### tb/pal_video_sync_sequencer_test.sv
`timescale 1ns / 100ps

module pal_video_sync_sequencer_test;
    import pvs_pkg::*;

    localparam int ROWS        = 256;
    localparam int PHASE_TICKS = 130;    // seven phases of random traffic
    localparam int LONG_HOLD   = 300;    // receiver hold that backs up the input
    localparam int SETTLE      = 8;      // lets the input and output registers drain
    localparam int IDLE_LIMIT  = 4000;   // cycles with no word moving anywhere

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = '0;      // tick
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [TDATA_W-1:0] m_tdata;             // slice_kind, colour, line_number,
                                             // slice_index, pixel_row
    logic               m_tlast;             // frame_end
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COLOR_W-1:0] cfg_data  = '0;

    int fail_count;
    int outstanding;
    int idle_cycles   = 0;
    bit sender_steady = 1'b0;   // no gaps between tick words while set
    bit hold_req      = 1'b0;   // asks the receiver for one long hold

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    pal_video_sync_sequencer #(
        .BITMAP_ROWS (ROWS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    pvs_slice_checker #(
        .BITMAP_ROWS (ROWS)
    ) slice_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // watchdog: any word moving on any channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // gap length: mostly none or short, now and then a long one
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // offer one tick word and hold it until taken; tvalid stays high when
    // no gap follows, so back-to-back words need no second assignment
    task automatic send_word(input logic tick);
        int gap;
        s_tdata  <= {7'd0, tick};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        gap = pick_gap(sender_steady);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering, let every predicted slice word come out, then let any
    // dropped tick-low word clear the pipeline too
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // border colour write, only ever issued while the sequencer is idle
    task automatic write_colour(input logic [COLOR_W-1:0] colour);
        cfg_data  <= colour;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls, stretches with none, and one long hold on request
    initial
    begin : receiver
        int low_cycles;
        int high_cycles;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req   = 1'b0;
                low_cycles = LONG_HOLD;
            end
            else
                low_cycles = pick_gap(1'b0);
            if (low_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (low_cycles) @(posedge clk);
            end
            m_tready <= 1'b1;
            high_cycles = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 200) :
                                                         $urandom_range(1, 6);
            repeat (high_cycles) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        logic [COLOR_W-1:0] colours [7] = '{4'd0, 4'd15, 4'd10, 4'd5, 4'd0, 4'd0, 4'd15};
        int phase;
        int ticks;
        colours[4] = $urandom_range(0, 15);
        colours[5] = $urandom_range(0, 15);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: top of frame with the brightest border, tick-low words
        // mixed in, first back to back and then with gaps
        write_colour(4'd15);
        sender_steady = 1'b1;
        send_word(1'b0);
        repeat (6) send_word(1'b1);
        send_word(1'b0);
        send_word(1'b0);
        repeat (10) send_word(1'b1);
        sender_steady = 1'b0;
        repeat (3)
        begin
            send_word(1'b0);
            send_word(1'b1);
        end
        wait_idle();

        // random phases, one border colour each
        for (phase = 0; phase < 7; phase++)
        begin
            write_colour(colours[phase]);
            ticks = 0;
            while (ticks < PHASE_TICKS)
            begin
                if (ticks % 250 == 0)
                    sender_steady = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) == 0)
                    send_word(1'b0);
                else
                begin
                    // sender keeps offering once the receiver starts its hold
                    if (phase == 1 && ticks == 60)
                    begin
                        hold_req = 1'b1;
                        wait (!hold_req);
                    end
                    send_word(1'b1);
                    ticks++;
                end
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
